@@ hdl/twhl_pkg.sv @@
package twhl_pkg;

    // fixed field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 24;

    // timeout register value after reset
    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 24'd1000;

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SEND = 2'd1;
    localparam logic [1:0] REQ_RECV = 2'd2;

    // link phases
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_S_IDLE      = 3'd1,
        PH_S_ACK_LOW   = 3'd2,
        PH_S_ACK_HIGH  = 3'd3,
        PH_R_DATA      = 3'd4,
        PH_R_DATA_HIGH = 3'd5
    } phase_t;

    // one result word from the core
    typedef struct packed {
        logic              red_pull_low;
        logic              white_pull_low;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic [BYTE_W-1:0] rx_byte;
    } result_t;

endpackage

@@ hdl/twhl_in_if.sv @@
interface twhl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic       red_level;
    logic       white_level;

    modport source (output valid, output req_type, output tx_byte,
                    output red_level, output white_level, input ready);
    modport sink   (input valid, input req_type, input tx_byte,
                    input red_level, input white_level, output ready);
endinterface

@@ hdl/twhl_out_if.sv @@
interface twhl_out_if;
    logic       valid;
    logic       ready;
    logic       red_pull_low;
    logic       white_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       timed_out;
    logic [7:0] rx_byte;

    modport source (output valid, output red_pull_low, output white_pull_low,
                    output busy_res, output done_res, output timed_out,
                    output rx_byte, input ready);
    modport sink   (input valid, input red_pull_low, input white_pull_low,
                    input busy_res, input done_res, input timed_out,
                    input rx_byte, output ready);
endinterface

@@ hdl/two_wire_handshake_link_port_unit.sv @@
// Two-wire open-drain handshake link port. Each input word is one tick: it carries the
// sampled red and white line levels and, while the port is idle, an optional request to
// send or receive one word of BITS_PER_WORD bits, LSB first, one bit per handshake.
// Every input word yields exactly one result word with the line drives, busy, done,
// timed_out and the received byte. The port takes one word per cycle while ready is
// high; the output register holds the result the cycle after acceptance, and ready
// drops only while that register holds an untaken result. timeout_ticks (reset 1000)
// sets the ticks allowed in each wait phase; zero means wait forever when receiving.
// Write it with timeout_we only while no transfer is in progress.
module two_wire_handshake_link_port_unit #(
    parameter int unsigned BITS_PER_WORD = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    twhl_in_if.sink                       link_in,
    twhl_out_if.source                    link_out,
    input  logic                          timeout_we,
    input  logic [twhl_pkg::COUNT_W-1:0]  timeout_wdata
);

    logic [twhl_pkg::COUNT_W-1:0] timeout_reg;
    logic                         out_valid_reg;
    twhl_pkg::result_t            result_reg;
    twhl_pkg::result_t            result;
    logic                         accept;

    // word handshake on the input side
    assign link_in.ready = !out_valid_reg || link_out.ready;
    assign accept        = link_in.valid && link_in.ready;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= twhl_pkg::TIMEOUT_RESET;
        end
        else if (timeout_we)
        begin
            timeout_reg <= timeout_wdata;
        end
    end

    twhl_core #(
        .BITS_PER_WORD (BITS_PER_WORD)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_type      (link_in.req_type),
        .tx_byte       (link_in.tx_byte),
        .red_level     (link_in.red_level),
        .white_level   (link_in.white_level),
        .timeout_ticks (timeout_reg),
        .result        (result)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (link_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign link_out.valid          = out_valid_reg;
    assign link_out.red_pull_low   = result_reg.red_pull_low;
    assign link_out.white_pull_low = result_reg.white_pull_low;
    assign link_out.busy_res       = result_reg.busy_res;
    assign link_out.done_res       = result_reg.done_res;
    assign link_out.timed_out      = result_reg.timed_out;
    assign link_out.rx_byte        = result_reg.rx_byte;

endmodule

@@ hdl/twhl_core.sv @@
module twhl_core #(
    parameter int unsigned BITS_PER_WORD = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [1:0]                      req_type,
    input  logic [twhl_pkg::BYTE_W-1:0]     tx_byte,
    input  logic                            red_level,
    input  logic                            white_level,
    input  logic [twhl_pkg::COUNT_W-1:0]    timeout_ticks,
    output twhl_pkg::result_t               result
);

    localparam int unsigned WIDE_W = (BITS_PER_WORD > twhl_pkg::BYTE_W) ?
                                     BITS_PER_WORD : twhl_pkg::BYTE_W;
    localparam int unsigned POS_W  = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BITS_PER_WORD - 1);

    twhl_pkg::phase_t                phase_reg, phase_next;
    logic                            receiving_reg, receiving_next;
    logic [POS_W-1:0]                bit_pos_reg, bit_pos_next;
    logic [BITS_PER_WORD-1:0]        shift_reg, shift_next;
    logic                            cur_bit_reg, cur_bit_next;
    logic [twhl_pkg::COUNT_W-1:0]    wait_count_reg, wait_count_next;
    logic                            red_drive_reg, red_drive_next;
    logic                            white_drive_reg, white_drive_next;

    logic                  unlimited;
    logic                  expired;
    logic                  waiting;
    logic                  met;
    logic                  tout;
    logic                  word_end;
    logic                  word_done;
    logic                  cmd_start;
    logic [WIDE_W-1:0]     tx_wide;
    logic [WIDE_W-1:0]     rx_wide;
    logic [BITS_PER_WORD-1:0] shift_in;

    // wait conditions for the current phase
    always_comb
    begin
        unlimited = receiving_reg && (timeout_ticks == '0);
        expired   = !unlimited && (wait_count_reg > timeout_ticks);
        cmd_start = (phase_reg == twhl_pkg::PH_IDLE) &&
                    ((req_type == twhl_pkg::REQ_SEND) || (req_type == twhl_pkg::REQ_RECV));
        waiting   = 1'b1;
        met       = 1'b0;
        unique case (phase_reg)
            twhl_pkg::PH_IDLE:        waiting = 1'b0;
            twhl_pkg::PH_S_IDLE:      met = red_level && white_level;
            twhl_pkg::PH_S_ACK_LOW:   met = !(cur_bit_reg ? red_level : white_level);
            twhl_pkg::PH_S_ACK_HIGH:  met = cur_bit_reg ? red_level : white_level;
            twhl_pkg::PH_R_DATA:      met = red_level != white_level;
            twhl_pkg::PH_R_DATA_HIGH: met = cur_bit_reg ? white_level : red_level;
            default:                  waiting = 1'b0;
        endcase
        tout      = waiting && !met && expired;
        word_end  = met && ((phase_reg == twhl_pkg::PH_S_ACK_HIGH) ||
                            (phase_reg == twhl_pkg::PH_R_DATA_HIGH));
        word_done = word_end && (bit_pos_reg == LAST_POS);
    end

    // next phase and wait counter
    always_comb
    begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        if (waiting && !met && !expired && (wait_count_reg != '1))
        begin
            wait_count_next = wait_count_reg + 1'b1;
        end
        unique case (phase_reg)
            twhl_pkg::PH_IDLE:
            begin
                if (cmd_start)
                begin
                    phase_next = (req_type == twhl_pkg::REQ_RECV) ?
                                 twhl_pkg::PH_R_DATA : twhl_pkg::PH_S_IDLE;
                    wait_count_next = '0;
                end
            end
            twhl_pkg::PH_S_IDLE:
            begin
                if (met)
                begin
                    phase_next      = twhl_pkg::PH_S_ACK_LOW;
                    wait_count_next = '0;
                end
            end
            twhl_pkg::PH_S_ACK_LOW:
            begin
                if (met)
                begin
                    phase_next      = twhl_pkg::PH_S_ACK_HIGH;
                    wait_count_next = '0;
                end
            end
            twhl_pkg::PH_S_ACK_HIGH:
            begin
                if (met)
                begin
                    phase_next      = word_done ? twhl_pkg::PH_IDLE : twhl_pkg::PH_S_IDLE;
                    wait_count_next = '0;
                end
            end
            twhl_pkg::PH_R_DATA:
            begin
                if (met)
                begin
                    phase_next      = twhl_pkg::PH_R_DATA_HIGH;
                    wait_count_next = '0;
                end
            end
            twhl_pkg::PH_R_DATA_HIGH:
            begin
                if (met)
                begin
                    phase_next      = word_done ? twhl_pkg::PH_IDLE : twhl_pkg::PH_R_DATA;
                    wait_count_next = '0;
                end
            end
            default:
            begin
                phase_next      = twhl_pkg::PH_IDLE;
                wait_count_next = '0;
            end
        endcase
        if (tout)
        begin
            phase_next      = twhl_pkg::PH_IDLE;
            wait_count_next = '0;
        end
    end

    // line drives, data shifting and result word
    always_comb
    begin
        tx_wide          = WIDE_W'(tx_byte);
        shift_in         = shift_reg >> 1;
        shift_in[BITS_PER_WORD-1] = cur_bit_reg;
        receiving_next   = receiving_reg;
        bit_pos_next     = bit_pos_reg;
        shift_next       = shift_reg;
        cur_bit_next     = cur_bit_reg;
        red_drive_next   = red_drive_reg;
        white_drive_next = white_drive_reg;
        unique case (phase_reg)
            twhl_pkg::PH_IDLE:
            begin
                if (cmd_start)
                begin
                    receiving_next   = (req_type == twhl_pkg::REQ_RECV);
                    shift_next       = (req_type == twhl_pkg::REQ_SEND) ?
                                       tx_wide[BITS_PER_WORD-1:0] : '0;
                    bit_pos_next     = '0;
                    cur_bit_next     = 1'b0;
                    red_drive_next   = 1'b0;
                    white_drive_next = 1'b0;
                end
            end
            twhl_pkg::PH_S_IDLE:
            begin
                if (met)
                begin
                    cur_bit_next = shift_reg[0];
                    if (shift_reg[0])
                    begin
                        white_drive_next = 1'b1;
                    end
                    else
                    begin
                        red_drive_next = 1'b1;
                    end
                end
            end
            twhl_pkg::PH_S_ACK_LOW:
            begin
                if (met)
                begin
                    red_drive_next   = 1'b0;
                    white_drive_next = 1'b0;
                end
            end
            twhl_pkg::PH_S_ACK_HIGH:
            begin
                if (met)
                begin
                    shift_next = shift_reg >> 1;
                end
            end
            twhl_pkg::PH_R_DATA:
            begin
                if (met)
                begin
                    cur_bit_next = red_level;
                    if (red_level)
                    begin
                        red_drive_next = 1'b1;
                    end
                    else
                    begin
                        white_drive_next = 1'b1;
                    end
                end
            end
            twhl_pkg::PH_R_DATA_HIGH:
            begin
                if (met)
                begin
                    red_drive_next   = 1'b0;
                    white_drive_next = 1'b0;
                    shift_next       = shift_in;
                end
            end
            default:
            begin
            end
        endcase
        // advance the bit position at the end of each handshake
        if (word_end)
        begin
            bit_pos_next = word_done ? '0 : POS_W'(bit_pos_reg + 1'b1);
        end
        if (tout)
        begin
            red_drive_next   = 1'b0;
            white_drive_next = 1'b0;
        end
        rx_wide               = WIDE_W'(shift_next);
        result.red_pull_low   = red_drive_next;
        result.white_pull_low = white_drive_next;
        result.busy_res       = (phase_next != twhl_pkg::PH_IDLE);
        result.done_res       = word_done || tout;
        result.timed_out      = tout;
        result.rx_byte        = (word_done && receiving_reg) ?
                                rx_wide[twhl_pkg::BYTE_W-1:0] : '0;
    end

    // state registers, advanced once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= twhl_pkg::PH_IDLE;
            receiving_reg   <= 1'b0;
            bit_pos_reg     <= '0;
            shift_reg       <= '0;
            cur_bit_reg     <= 1'b0;
            wait_count_reg  <= '0;
            red_drive_reg   <= 1'b0;
            white_drive_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            receiving_reg   <= receiving_next;
            bit_pos_reg     <= bit_pos_next;
            shift_reg       <= shift_next;
            cur_bit_reg     <= cur_bit_next;
            wait_count_reg  <= wait_count_next;
            red_drive_reg   <= red_drive_next;
            white_drive_reg <= white_drive_next;
        end
    end

endmodule

@@ hdl/twhl_checker.sv @@
module twhl_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic red_pull_low,
    input logic white_pull_low,
    input logic busy_res,
    input logic done_res,
    input logic timed_out
);

    // a result word stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped before it was taken");

    // the port never pulls both lines at once
    a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(red_pull_low && white_pull_low))
        else $error("both lines pulled low");

    // a timeout ends the transfer and releases every line
    a_tout_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> done_res && !red_pull_low && !white_pull_low)
        else $error("timeout without release of the lines");

    // a finished transfer leaves the port idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("busy with done");

endmodule

bind two_wire_handshake_link_port_unit twhl_checker u_twhl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (link_out.valid),
    .out_ready      (link_out.ready),
    .red_pull_low   (link_out.red_pull_low),
    .white_pull_low (link_out.white_pull_low),
    .busy_res       (link_out.busy_res),
    .done_res       (link_out.done_res),
    .timed_out      (link_out.timed_out)
);
